// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ----- rtl/rnc_pkg.sv -----
// Constants, types and helpers for the RGB to NV12 converter.
`default_nettype none

package rnc_pkg;

  // Frame geometry
  localparam int MaxWidth   = 2048;
  localparam int MaxHeight  = 2048;
  localparam int SizeW      = 12;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int StoreDepth = MaxWidth / 2;

  // Arithmetic widths
  localparam int PixW      = 8;
  localparam int ChromaW   = 24;          // per-pixel chroma, Q16
  localparam int PairW     = ChromaW + 1; // two-pixel sum
  localparam int TotW      = ChromaW + 2; // four-pixel sum
  localparam int LumaShift   = 16;
  localparam int ChromaShift = 18;

  // BT.601 coefficients, Q0.16
  localparam logic [ChromaW-1:0] CoefYr = 24'd16843;
  localparam logic [ChromaW-1:0] CoefYg = 24'd33030;
  localparam logic [ChromaW-1:0] CoefYb = 24'd6423;
  localparam logic [ChromaW-1:0] YBias  = 24'((16 << 16) + 32768);
  localparam logic [ChromaW-1:0] CoefUr = 24'd9699;
  localparam logic [ChromaW-1:0] CoefUg = 24'd19071;
  localparam logic [ChromaW-1:0] CoefUb = 24'd28770;
  localparam logic [ChromaW-1:0] CoefVr = 24'd28770;
  localparam logic [ChromaW-1:0] CoefVg = 24'd24117;
  localparam logic [ChromaW-1:0] CoefVb = 24'd4653;
  localparam logic [ChromaW-1:0] UvBias = 24'(128 << 16);
  localparam logic [TotW-1:0]    ChromaRound = TotW'(1 << 17);

  // Streams
  localparam int InDataW    = 3 * PixW;
  localparam int OutFieldsW = ColW + RowW + 2 * PixW;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;
  localparam int OutUserW   = 2;

  // Configuration port
  localparam int PaddrW = 3;
  localparam int PdataW = 32;
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;
  localparam logic [SizeW-1:0] WidthReset  = 12'd640;
  localparam logic [SizeW-1:0] HeightReset = 12'd480;

  // Plane codes
  localparam logic PlaneLuma   = 1'b0;
  localparam logic PlaneChroma = 1'b1;

  typedef struct packed {
    logic            plane;
    logic [ColW-1:0] column;
    logic [RowW-1:0] line;
    logic [PixW-1:0] first_value;
    logic [PixW-1:0] second_value;
    logic            frame_done;
    logic            run_last;
  } out_word_t;

  // Even size, at least two, at most the given limit
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] size_v,
                                                input logic [SizeW-1:0] max_v);
    logic [SizeW-1:0] s;
    s = {size_v[SizeW-1:1], 1'b0};
    if (s < SizeW'(2)) s = SizeW'(2);
    if (s > max_v) s = max_v;
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rgb_to_nv12_converter_core.sv -----
// RGB to NV12 (BT.601 studio range) converter: top level.
//
//  channel   dir  word                                   handshake
//  s_axis    in   {blue, green, red}                     tvalid/tready
//  m_axis    out  {pad, V, U/Y, line, column} +user,last tvalid/tready
//  apb       in   frame_width @0x0, frame_height @0x4    psel/penable, pready=1
//
// One pixel per clock sustained while m_axis_tready stays high; a pixel that
// closes a 2x2 block gives two words on the single output port and holds
// the input while the second waits. A pixel's luma word reaches m_axis via
// the input stage (loaded on the accepting edge), multiply stage, output register.
// The line store is a 1024 x 50 synchronous RAM, one read and one write
// port; it needs no clearing after reset. Reset is asynchronous, active low.
`default_nettype none
`include "assert_macros.svh"

module rgb_to_nv12_converter_core import rnc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // pixel input
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // red, green, blue
  // result output
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,  // column, line, first_value, second_value, pad
  output logic [OutUserW-1:0]      m_axis_tuser,  // plane, frame_done
  output logic                     m_axis_tlast,  // run_last
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PaddrW-1:0]   paddr,
  input  wire logic [PdataW-1:0]   pwdata,
  output logic [PdataW-1:0]        prdata,
  output logic                     pready
);

  // Configuration registers
  logic [SizeW-1:0] width_q, height_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_wr) begin
      if (paddr[PaddrW-1] == RegFrameHeight) begin
        height_q <= pwdata[SizeW-1:0];
      end else begin
        width_q <= pwdata[SizeW-1:0];
      end
    end
  end

  assign prdata = (paddr[PaddrW-1] == RegFrameHeight) ? PdataW'(height_q)
                                                      : PdataW'(width_q);

  // Pipeline control
  logic in_acc, a_free, b_free, adv_b, adv_c;
  logic a_v_q, b_v_q, out_v_q, pend_v_q;

  assign adv_c  = b_v_q && (!out_v_q || m_axis_tready) && !pend_v_q;
  assign b_free = !b_v_q || adv_c;
  assign adv_b  = a_v_q && b_free;
  assign a_free = !a_v_q || b_free;
  assign s_axis_tready = a_free;
  assign in_acc = s_axis_tvalid && a_free;

  // Raster position
  logic [ColW-1:0]  col_q;
  logic [RowW-1:0]  row_q;
  logic [SizeW-1:0] eff_w, eff_h;
  logic             row_end, frame_end;

  assign eff_w     = eff_size(width_q, SizeW'(MaxWidth));
  assign eff_h     = eff_size(height_q, SizeW'(MaxHeight));
  assign row_end   = (SizeW'(col_q) + SizeW'(1)) >= eff_w;
  assign frame_end = row_end && ((SizeW'(row_q) + SizeW'(1)) >= eff_h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // Stage A: registered pixel and position
  logic [PixW-1:0] a_r_q, a_g_q, a_b_q;
  logic [ColW-1:0] a_col_q;
  logic [RowW-1:0] a_row_q;
  logic            a_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_free) begin
      a_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_r_q    <= s_axis_tdata[PixW-1:0];
      a_g_q    <= s_axis_tdata[2*PixW-1:PixW];
      a_b_q    <= s_axis_tdata[3*PixW-1:2*PixW];
      a_col_q  <= col_q;
      a_row_q  <= row_q;
      a_fend_q <= frame_end;
    end
  end

  // Per-pixel luma and chroma (chroma always in range, so mod 2^24 is exact)
  logic [ChromaW-1:0] y_sum, up_d, vp_d;
  logic [ChromaW-1:0] r_x, g_x, b_x;

  assign r_x   = ChromaW'(a_r_q);
  assign g_x   = ChromaW'(a_g_q);
  assign b_x   = ChromaW'(a_b_q);
  assign y_sum = CoefYr * r_x + CoefYg * g_x + CoefYb * b_x + YBias;
  assign up_d  = UvBias + CoefUb * b_x - CoefUr * r_x - CoefUg * g_x;
  assign vp_d  = UvBias + CoefVr * r_x - CoefVg * g_x - CoefVb * b_x;

  // Stage B: products summed, line store read data alongside
  logic [PixW-1:0]    b_y_q;
  logic [ChromaW-1:0] b_up_q, b_vp_q;
  logic [ColW-1:0]    b_col_q;
  logic [RowW-1:0]    b_row_q;
  logic               b_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_free) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_b) begin
      b_y_q    <= y_sum[LumaShift +: PixW];
      b_up_q   <= up_d;
      b_vp_q   <= vp_d;
      b_col_q  <= a_col_q;
      b_row_q  <= a_row_q;
      b_fend_q <= a_fend_q;
    end
  end

  // Line store: upper-row pair sums {U, V}. The read for an odd pixel of an
  // odd row trails the write of the same entry by at least one pixel, so
  // that read and the write never touch one entry in the same cycle.
  logic [2*PairW-1:0] line_mem [StoreDepth];
  logic [2*PairW-1:0] rd_q;
  logic               wr_en;
  logic [PairW-1:0]   su, sv;

  assign wr_en = adv_c && b_col_q[0] && !b_row_q[0];

  always_ff @(posedge clk_i) begin
    if (adv_b) begin
      rd_q <= line_mem[a_col_q[ColW-1:1]];
    end
    if (wr_en) begin
      line_mem[b_col_q[ColW-1:1]] <= {su, sv};
    end
  end

  // Left-pixel chroma of the current pair
  logic [ChromaW-1:0] pair_u_q, pair_v_q;

  always_ff @(posedge clk_i) begin
    if (adv_c && !b_col_q[0]) begin
      pair_u_q <= b_up_q;
      pair_v_q <= b_vp_q;
    end
  end

  // Block sums and rounding
  logic [TotW-1:0] tu, tv;
  logic            chroma;

  assign su = PairW'(pair_u_q) + PairW'(b_up_q);
  assign sv = PairW'(pair_v_q) + PairW'(b_vp_q);
  assign tu = TotW'(su) + TotW'(rd_q[2*PairW-1:PairW]) + ChromaRound;
  assign tv = TotW'(sv) + TotW'(rd_q[PairW-1:0]) + ChromaRound;
  assign chroma = b_col_q[0] && b_row_q[0];

  out_word_t luma_w, chroma_w;

  always_comb begin
    luma_w.plane        = PlaneLuma;
    luma_w.column       = b_col_q;
    luma_w.line         = b_row_q;
    luma_w.first_value  = b_y_q;
    luma_w.second_value = '0;
    luma_w.frame_done   = 1'b0;
    luma_w.run_last     = !chroma;

    chroma_w.plane        = PlaneChroma;
    chroma_w.column       = ColW'(b_col_q[ColW-1:1]);
    chroma_w.line         = RowW'(b_row_q[RowW-1:1]);
    chroma_w.first_value  = tu[ChromaShift +: PixW];
    chroma_w.second_value = tv[ChromaShift +: PixW];
    chroma_w.frame_done   = b_fend_q;
    chroma_w.run_last     = 1'b1;
  end

  // Output register plus one pending chroma word
  out_word_t out_q, pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else if (adv_c) begin
      out_v_q  <= 1'b1;
      pend_v_q <= chroma;
    end else if (out_v_q && m_axis_tready) begin
      out_v_q  <= pend_v_q;
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_c) begin
      out_q  <= luma_w;
      pend_q <= chroma_w;
    end else if (out_v_q && m_axis_tready && pend_v_q) begin
      out_q <= pend_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OutDataW'({out_q.second_value, out_q.first_value,
                                    out_q.line, out_q.column});
  assign m_axis_tuser  = {out_q.frame_done, out_q.plane};
  assign m_axis_tlast  = out_q.run_last;

  // Checks
  `ASSERT_ALWAYS(a_pend_needs_out, pend_v_q |-> out_v_q, "pending chroma without output word")
  `ASSERT_ALWAYS(a_pend_after_luma, pend_v_q |-> !out_q.run_last, "chroma queued behind a closing word")
  `ASSERT_NEVER(a_mem_same_entry, wr_en && adv_b && (a_col_q[ColW-1:1] == b_col_q[ColW-1:1]) && a_col_q[0] && a_row_q[0], "line store read and write collide")

endmodule

`default_nettype wire
